### src/b64lw_pkg.sv
// Shared types, constants and the base64 alphabet function of the line-wrapping encoder.
`timescale 1ns / 1ps
package b64lw_pkg;

	localparam int unsigned B64LW_QUEUE_DEPTH = 2;

	localparam logic [7:0] LINE_FEED = 8'd10;
	localparam logic [7:0] PAD_CHAR  = 8'd61;
	localparam logic [7:0] PLUS_CHAR = 8'd43;
	localparam logic [7:0] SLASH_CHAR = 8'd47;

	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            lf;
		logic            last;
	} b64lw_grp_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] w;
		w = {2'b00, s};
		if (s <= 6'd25) begin
			return w + 8'd65;
		end else if (s <= 6'd51) begin
			return w + 8'd71;
		end else if (s <= 6'd61) begin
			return w - 8'd4;
		end else if (s == 6'd62) begin
			return PLUS_CHAR;
		end else begin
			return SLASH_CHAR;
		end
	endfunction

endpackage

### src/b64lw_ifs.sv
// Handshake channel interfaces for raw bytes, encoded characters and configuration.
`timescale 1ns / 1ps
interface b64lw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64lw_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;
	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface

interface b64lw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_groups;
	modport source (output valid, output line_groups, input ready);
	modport sink (input valid, input line_groups, output ready);
endinterface

### src/base64_encoder_line_wrap_unit.sv
// Top level of the streaming base64 encoder with optional line feeds.
`timescale 1ns / 1ps
// Usage:
// The raw channel takes one binary byte per transfer, with last_byte set on the
// final byte of a message. The enc channel delivers one ASCII character per
// transfer: base64 characters, '=' padding and line feeds, with out_last set on
// the final character of the message.
// The cfg channel writes line_groups, the number of four-character groups per
// line; zero disables line feeds. It is always ready and should be written
// only while the encoder is idle.
// Path: a completed group goes through the queue and the group register to
// the output register, from which its first character is sent.
// Throughput: the back end sends one character per cycle while a group waits
// and the receiver is ready; a group of three bytes gives four characters, or
// five with a line feed.
// A queue of encoded groups decouples the two ends, so bytes keep being taken
// while the receiver stalls, until the queue fills.
// Reset clears the count of held bytes, the line position, line_groups and the queue.
module base64_encoder_line_wrap_unit #(
	parameter int unsigned QUEUE_DEPTH = b64lw_pkg::B64LW_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	b64lw_cfg_if.sink     cfg,
	b64lw_byte_if.sink    raw,
	b64lw_char_if.source  enc
);
	import b64lw_pkg::*;

	logic       push;
	logic       full;
	logic       pop;
	logic       avail;
	b64lw_grp_t wr_grp;
	b64lw_grp_t rd_grp;

	b64lw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.raw    (raw),
		.push   (push),
		.grp    (wr_grp),
		.full   (full)
	);

	b64lw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (wr_grp),
		.full   (full),
		.pop    (pop),
		.rd_grp (rd_grp),
		.avail  (avail)
	);

	b64lw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.head   (rd_grp),
		.pop    (pop),
		.enc    (enc)
	);

endmodule

### src/b64lw_front.sv
// Front end: accepts bytes, gathers groups of three, encodes them and tracks line length.
`timescale 1ns / 1ps
module b64lw_front (
	input  logic                clk,
	input  logic                arst_n,
	b64lw_cfg_if.sink           cfg,
	b64lw_byte_if.sink          raw,
	output logic                push,
	output b64lw_pkg::b64lw_grp_t grp,
	input  logic                full
);
	import b64lw_pkg::*;

	logic [7:0]  line_groups_q;
	logic [7:0]  pend0_q;
	logic [7:0]  pend1_q;
	logic [1:0]  cnt_q;
	logic [7:0]  gol_q;
	logic        accept;
	logic        emit;
	logic [1:0]  nbytes;
	logic [7:0]  o0;
	logic [7:0]  o1;
	logic [7:0]  o2;
	logic [23:0] word;
	logic [8:0]  gnext;
	logic        lf;

	assign cfg.ready = 1'b1;
	assign raw.ready = !full;
	assign accept = raw.valid && raw.ready;
	assign emit = raw.last_byte || (cnt_q == 2'd2);
	assign push = accept && emit;

	always_comb begin
		nbytes = (cnt_q == 2'd2) ? 2'd3 : cnt_q + 2'd1;
		o0 = (nbytes == 2'd1) ? raw.data_byte : pend0_q;
		o1 = (nbytes == 2'd2) ? raw.data_byte : ((nbytes == 2'd3) ? pend1_q : 8'd0);
		o2 = (nbytes == 2'd3) ? raw.data_byte : 8'd0;
		word = {o0, o1, o2};
		gnext = {1'b0, gol_q} + 9'd1;
		lf = (line_groups_q != 8'd0) &&
			((gnext >= {1'b0, line_groups_q}) || raw.last_byte);
		grp.chars[0] = sextet_char(word[23:18]);
		grp.chars[1] = sextet_char(word[17:12]);
		grp.chars[2] = (nbytes >= 2'd2) ? sextet_char(word[11:6]) : PAD_CHAR;
		grp.chars[3] = (nbytes == 2'd3) ? sextet_char(word[5:0]) : PAD_CHAR;
		grp.lf = lf;
		grp.last = raw.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_groups_q <= 8'd0;
			cnt_q <= 2'd0;
			gol_q <= 8'd0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				line_groups_q <= cfg.line_groups;
			end
			if (push) begin
				cnt_q <= 2'd0;
				if (raw.last_byte || lf) begin
					gol_q <= 8'd0;
				end else if (line_groups_q != 8'd0) begin
					gol_q <= gnext[7:0];
				end
			end else if (accept) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !emit) begin
			if (cnt_q[0]) begin
				pend1_q <= raw.data_byte;
			end else begin
				pend0_q <= raw.data_byte;
			end
		end
	end

endmodule

### src/b64lw_fifo.sv
// Short queue of encoded groups between the front and back ends.
`timescale 1ns / 1ps
module b64lw_fifo #(
	parameter int unsigned DEPTH = b64lw_pkg::B64LW_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64lw_pkg::b64lw_grp_t wr_grp,
	output logic                  full,
	input  logic                  pop,
	output b64lw_pkg::b64lw_grp_t rd_grp,
	output logic                  avail
);
	import b64lw_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64lw_grp_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign avail = (cnt_q != '0);
	assign rd_grp = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_grp;
		end
	end

endmodule

### src/b64lw_back.sv
// Back end: serializes each encoded group into characters through an output register.
`timescale 1ns / 1ps
module b64lw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  avail,
	input  b64lw_pkg::b64lw_grp_t head,
	output logic                  pop,
	b64lw_char_if.source          enc
);
	import b64lw_pkg::*;

	b64lw_grp_t cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       ld;
	logic       fin;
	logic [7:0] next_char;

	assign enc.valid = out_valid_q;
	assign enc.out_char = out_char_q;
	assign enc.out_last = out_last_q;

	assign ld = cur_valid_q && (!out_valid_q || enc.ready);
	assign fin = ld && (((idx_q == 3'd3) && !cur_q.lf) || (idx_q == 3'd4));
	assign pop = avail && (!cur_valid_q || fin);
	assign next_char = (idx_q == 3'd4) ? LINE_FEED : cur_q.chars[idx_q[1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q <= 3'd0;
			end else if (fin) begin
				cur_valid_q <= 1'b0;
			end else if (ld) begin
				idx_q <= idx_q + 3'd1;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (enc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (ld) begin
			out_char_q <= next_char;
			out_last_q <= cur_q.last && fin;
		end
	end

	a_lf_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && (idx_q == 3'd4)) |=> (out_char_q == LINE_FEED))
		else $error("Fifth character of a group is not a line feed.");

	a_lf_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && (idx_q == 3'd4)) |-> cur_q.lf)
		else $error("Line feed slot reached for a group without a line feed.");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= 3'd4))
		else $error("Character index ran past the end of a group.");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !enc.ready) |=> (out_valid_q && $stable(out_char_q)))
		else $error("Stalled character was overwritten.");

endmodule

### tb/base64_encoder_line_wrap_unit_tb.sv
// Self-checking testbench for the line-wrapping base64 encoder with a built-in predictor.
`timescale 1ns / 1ps
module base64_encoder_line_wrap_unit_tb;
	import b64lw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] DIGIT_0 = 8'h30;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} raw_byte_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	logic clk;
	logic arst_n;

	b64lw_cfg_if  cfg_ch ();
	b64lw_byte_if raw_ch ();
	b64lw_char_if enc_ch ();

	base64_encoder_line_wrap_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.raw    (raw_ch),
		.enc    (enc_ch)
	);

	raw_byte_t   byte_q[$];
	enc_char_t   char_expect_q[$];

	logic [7:0]  line_groups_copy;
	logic [7:0]  held_bytes[2];
	logic [1:0]  held_count;
	logic [7:0]  groups_done;

	logic        raw_taken;
	logic        calm;
	int unsigned send_gap;
	int unsigned recv_gap;
	int unsigned cycle_count;
	int unsigned error_count;
	int unsigned bytes_sent;
	int unsigned chars_checked;
	int unsigned messages_sent;
	int unsigned line_feeds_seen;
	int unsigned cfg_writes;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] b64_symbol(input logic [5:0] s);
		if (s < 6'd26) begin
			return UPPER_A + 8'(s);
		end else if (s < 6'd52) begin
			return LOWER_A + 8'(s - 6'd26);
		end else if (s < 6'd62) begin
			return DIGIT_0 + 8'(s - 6'd52);
		end else if (s == 6'd62) begin
			return PLUS_CHAR;
		end
		return SLASH_CHAR;
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic last);
		enc_char_t c;
		c.ch = ch;
		c.last = last;
		char_expect_q.push_back(c);
	endtask

	// Works out the characters caused by one accepted byte.
	task automatic encode_byte(input logic [7:0] b, input logic last);
		int unsigned nb;
		logic [23:0] w;
		logic        lf;
		logic [8:0]  g;
		if (!last && held_count < 2) begin
			held_bytes[held_count[0]] = b;
			held_count = held_count + 2'd1;
			return;
		end
		nb = held_count + 1;
		case (nb)
			1: w = {b, 16'h0000};
			2: w = {held_bytes[0], b, 8'h00};
			default: w = {held_bytes[0], held_bytes[1], b};
		endcase
		lf = 1'b0;
		if (line_groups_copy != 8'd0) begin
			g = {1'b0, groups_done} + 9'd1;
			if (g >= {1'b0, line_groups_copy} || last) begin
				lf = 1'b1;
				groups_done = 8'd0;
			end else begin
				groups_done = g[7:0];
			end
		end
		push_char(b64_symbol(w[23:18]), 1'b0);
		push_char(b64_symbol(w[17:12]), 1'b0);
		push_char(nb >= 2 ? b64_symbol(w[11:6]) : PAD_CHAR, 1'b0);
		push_char(nb >= 3 ? b64_symbol(w[5:0]) : PAD_CHAR, last && !lf);
		if (lf) begin
			push_char(LINE_FEED, last);
		end
		held_count = 2'd0;
		held_bytes[0] = 8'd0;
		held_bytes[1] = 8'd0;
		if (last) begin
			groups_done = 8'd0;
		end
	endtask

	always @(posedge clk) begin
		enc_char_t e;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d characters outstanding",
				cycle_count, char_expect_q.size());
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				line_groups_copy = cfg_ch.line_groups;
				cfg_writes++;
			end
			raw_taken = raw_ch.valid && raw_ch.ready;
			if (raw_taken) begin
				encode_byte(raw_ch.data_byte, raw_ch.last_byte);
				void'(byte_q.pop_front());
				bytes_sent++;
				if (raw_ch.last_byte) begin
					messages_sent++;
				end
			end
			if (enc_ch.valid && enc_ch.ready) begin
				if (char_expect_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected character: expected none, actual char %0d last %0b",
						$time, enc_ch.out_char, enc_ch.out_last);
				end else begin
					e = char_expect_q.pop_front();
					chars_checked++;
					if (e.ch == LINE_FEED) begin
						line_feeds_seen++;
					end
					if (enc_ch.out_char !== e.ch) begin
						error_count++;
						$display("%0t: out_char mismatch: expected %0d actual %0d",
							$time, e.ch, enc_ch.out_char);
					end
					if (enc_ch.out_last !== e.last) begin
						error_count++;
						$display("%0t: out_last mismatch: expected %0b actual %0b",
							$time, e.last, enc_ch.out_last);
					end
				end
			end
		end
	end

	// Byte sender: holds an offered byte until its transfer, idles in random bursts unless calm is set.
	always @(negedge clk) begin
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
		end else if (raw_ch.valid && !raw_taken) begin
		end else if (send_gap != 0) begin
			raw_ch.valid <= 1'b0;
			send_gap = send_gap - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			raw_ch.valid <= 1'b0;
			send_gap = $urandom_range(0, 11);
		end else if (byte_q.size() != 0) begin
			raw_ch.valid <= 1'b1;
			raw_ch.data_byte <= byte_q[0].data;
			raw_ch.last_byte <= byte_q[0].last;
		end else begin
			raw_ch.valid <= 1'b0;
		end
	end

	// Character receiver: stalls in random bursts unless calm is set.
	always @(negedge clk) begin
		if (recv_gap != 0) begin
			enc_ch.ready <= 1'b0;
			recv_gap = recv_gap - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			enc_ch.ready <= 1'b0;
			recv_gap = $urandom_range(0, 11);
		end else begin
			enc_ch.ready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] data, input logic last);
		raw_byte_t r;
		r.data = data;
		r.last = last;
		byte_q.push_back(r);
	endtask

	task automatic add_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			push_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	task automatic add_random_messages(input int unsigned budget);
		int unsigned n;
		int unsigned len;
		n = 0;
		while (n < budget) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			add_message(len);
			n += len;
		end
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || char_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_line_groups(input logic [7:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.line_groups <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.line_groups = 8'd0;
		raw_ch.valid = 1'b0;
		raw_ch.data_byte = 8'd0;
		raw_ch.last_byte = 1'b0;
		enc_ch.ready = 1'b0;
		raw_taken = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		cycle_count = 0;
		error_count = 0;
		bytes_sent = 0;
		chars_checked = 0;
		messages_sent = 0;
		line_feeds_seen = 0;
		cfg_writes = 0;
		line_groups_copy = 8'd0;
		held_bytes[0] = 8'd0;
		held_bytes[1] = 8'd0;
		held_count = 2'd0;
		groups_done = 8'd0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The reset line length of zero leaves out line feeds; the groups below
		// cover both pad lengths, the plus and slash symbols and extreme bytes.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFB, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hBE, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'h83, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFE, 1'b1);
		wait_drained();

		// One group per line: every group ends its line, the final one too.
		write_line_groups(8'd1);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h3C, 1'b1);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);
		wait_drained();

		write_line_groups(8'd255);
		add_random_messages(14);
		wait_drained();

		write_line_groups(8'd2);
		add_random_messages(14);
		wait_drained();

		write_line_groups(8'd0);
		add_random_messages(12);
		wait_drained();

		// Lower the line length in the middle of a line while a byte is held,
		// with the sender paused until every character has come out.
		write_line_groups(8'd8);
		add_message(9);
		for (int i = 0; i < 16; i++) begin
			push_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		wait_drained();
		write_line_groups(8'd2);
		push_byte(8'($urandom_range(0, 255)), 1'b0);
		push_byte(8'($urandom_range(0, 255)), 1'b0);
		add_message(7);
		wait_drained();

		write_line_groups(8'd3);
		add_random_messages(14);
		wait_drained();

		write_line_groups(8'($urandom_range(1, 254)));
		add_random_messages(12);
		wait_drained();

		calm = 1'b1;
		write_line_groups(8'd1);
		add_random_messages(12);
		wait_drained();

		$display("Encoded %0d bytes in %0d messages into %0d checked characters",
			bytes_sent, messages_sent, chars_checked);
		$display("Line length written %0d times; %0d line feeds checked; %0d errors",
			cfg_writes, line_feeds_seen, error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
